// File: sv/dfs_pkg.sv
// Package for the depth-first path enumerator: sizes, item and event codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package dfs_pkg;

  localparam int MAX_NODES = 32;
  localparam int NODE_W    = 5;
  localparam int DEPTH_W   = 6;
  localparam int ROW_W     = 32;
  localparam int KIND_W    = 2;
  localparam int EVENT_W   = 2;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_NODES);
  localparam logic [DEPTH_W-1:0] COUNT_RESET = DEPTH_W'(32);

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

  localparam logic [EVENT_W-1:0] EV_EXTEND  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CIRCUIT = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DONE    = 2'd2;
  localparam logic [EVENT_W-1:0] EV_REJECT  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NODE_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic [NODE_W-1:0] source_node;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [DEPTH_W-1:0] cursor;
  } frame_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic reload;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic reload;
    logic out_free;
  } stat_t;

endpackage

// File: sv/dfs_if.sv
// Handshake channel interfaces of the path enumerator: input items, result
// items and configuration writes. Depends on dfs_pkg.
interface dfs_item_if;
  import dfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NODE_W-1:0] row_index;
  logic [ROW_W-1:0]  row_bits;
  logic [NODE_W-1:0] source_node;
  modport source (output valid, kind, row_index, row_bits, source_node, input ready);
  modport sink (input valid, kind, row_index, row_bits, source_node, output ready);
endinterface

interface dfs_result_if;
  import dfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [NODE_W-1:0]  node;
  logic [DEPTH_W-1:0] depth;
  modport source (output valid, event_res, node, depth, input ready);
  modport sink (input valid, event_res, node, depth, output ready);
endinterface

interface dfs_cfg_if;
  import dfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/dfs_path_enumerator_core.sv
// Top level of the depth-first simple path enumerator.
// Depends on dfs_pkg, the channel interfaces, dfs_ctrl and dfs_datapath.
//
// Input channel in_ch carries items: a load writes one adjacency row, a start
// begins a walk from source_node, a step advances the walk by one edge test or one pop.
// Result channel out_ch carries at most one event per item: path extended,
// circuit found, walk finished or start rejected, with node and stack depth.
// The configuration channel cfg_ch writes node_count; it is always ready.
//
// An item is captured into the item register when it is accepted and is then
// executed in the execute state, which writes any result to the output register;
// no new item is taken until that item is done. A step that pops a node while the
// stack stays non-empty goes on to a reload state, which loads the new top frame
// from the registered read port of the stack frame memory.
// Results are held in an output register; a new item is accepted while an
// earlier result waits, and only an item that must emit while the register is
// still full holds in its execute cycle until the receiver takes the result.
// Reset clears all adjacency rows and path marks, sets node_count to 32 and
// leaves the walk idle; the stack frame memory needs no clearing.
module dfs_path_enumerator_core
  import dfs_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  dfs_item_if.sink    in_ch,
  dfs_result_if.source out_ch,
  dfs_cfg_if.sink     cfg_ch
);

  cmd_t  cmd;
  stat_t stat;
  item_t item;

  assign item = '{kind: in_ch.kind, row_index: in_ch.row_index,
                  row_bits: in_ch.row_bits, source_node: in_ch.source_node};
  assign cfg_ch.ready = 1'b1;

  dfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dfs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_event (out_ch.event_res),
    .out_node  (out_ch.node),
    .out_depth (out_ch.depth)
  );

endmodule

// File: sv/dfs_ctrl.sv
// Controller of the path enumerator: sequences capture, execute and stack
// reload. Depends on dfs_pkg.
module dfs_ctrl
  import dfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.emit || stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.reload ? S_POP : S_IDLE;
        end
      end
      S_POP: begin
        cmd.reload = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/dfs_datapath.sv
// Datapath of the path enumerator: adjacency rows, path marks, top-of-stack
// registers, the stack frame memory and the result register. Depends on dfs_pkg.
module dfs_datapath
  import dfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  item_t              item,
  input  logic               cfg_we,
  input  logic [DEPTH_W-1:0] cfg_data,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [EVENT_W-1:0] out_event,
  output logic [NODE_W-1:0]  out_node,
  output logic [DEPTH_W-1:0] out_depth
);

  logic [ROW_W-1:0]     adj_r [MAX_NODES];
  logic [MAX_NODES-1:0] onpath_r, onpath_nxt;
  logic [DEPTH_W-1:0]   nc_r;
  logic [DEPTH_W-1:0]   sd_r, sd_nxt;
  logic                 walk_r, walk_nxt;
  logic [NODE_W-1:0]    top_r, top_nxt;
  logic [DEPTH_W-1:0]   cur_r, cur_nxt;
  item_t                item_r;
  frame_t               stk_mem [MAX_NODES];
  frame_t               rd_q;
  logic                 push_we;
  logic [NODE_W-1:0]    wr_addr, rd_addr;
  logic [DEPTH_W-1:0]   n_act;
  logic                 edge_bit;
  logic                 emit;
  logic                 need_reload;
  logic [EVENT_W-1:0]   ev_nxt;
  logic [NODE_W-1:0]    node_nxt;
  logic [DEPTH_W-1:0]   depth_nxt;
  logic                 out_valid_r;
  logic [EVENT_W-1:0]   out_event_r;
  logic [NODE_W-1:0]    out_node_r;
  logic [DEPTH_W-1:0]   out_depth_r;

  assign n_act    = (nc_r > MAX_DEPTH) ? MAX_DEPTH : nc_r;
  assign edge_bit = adj_r[top_r][cur_r[NODE_W-1:0]];
  assign wr_addr  = NODE_W'(sd_r - 1'b1);
  assign rd_addr  = NODE_W'(sd_r - 2'd2);

  always_comb begin
    onpath_nxt  = onpath_r;
    sd_nxt      = sd_r;
    walk_nxt    = walk_r;
    top_nxt     = top_r;
    cur_nxt     = cur_r;
    push_we     = 1'b0;
    emit        = 1'b0;
    need_reload = 1'b0;
    ev_nxt      = EV_EXTEND;
    node_nxt    = top_r;
    depth_nxt   = sd_r;
    case (item_r.kind)
      KIND_START: begin
        if (DEPTH_W'(item_r.source_node) >= n_act) begin
          emit      = 1'b1;
          ev_nxt    = EV_REJECT;
          node_nxt  = item_r.source_node;
          depth_nxt = '0;
        end else begin
          onpath_nxt                     = '0;
          onpath_nxt[item_r.source_node] = 1'b1;
          top_nxt                        = item_r.source_node;
          cur_nxt                        = '0;
          sd_nxt                         = DEPTH_W'(1);
          walk_nxt                       = 1'b1;
        end
      end
      KIND_STEP: begin
        if (!walk_r || sd_r == '0 || sd_r > MAX_DEPTH) begin
          walk_nxt = 1'b0;
        end else if (cur_r < n_act) begin
          cur_nxt  = cur_r + 1'b1;
          node_nxt = cur_r[NODE_W-1:0];
          if (edge_bit) begin
            if (onpath_r[cur_r[NODE_W-1:0]]) begin
              emit   = 1'b1;
              ev_nxt = EV_CIRCUIT;
            end else if (sd_r < MAX_DEPTH) begin
              push_we                     = 1'b1;
              top_nxt                     = cur_r[NODE_W-1:0];
              cur_nxt                     = '0;
              sd_nxt                      = sd_r + 1'b1;
              onpath_nxt[cur_r[NODE_W-1:0]] = 1'b1;
              emit                        = 1'b1;
              ev_nxt                      = EV_EXTEND;
              depth_nxt                   = sd_r + 1'b1;
            end
          end
        end else begin
          onpath_nxt[top_r] = 1'b0;
          sd_nxt            = sd_r - 1'b1;
          if (sd_r == DEPTH_W'(1)) begin
            walk_nxt  = 1'b0;
            emit      = 1'b1;
            ev_nxt    = EV_DONE;
            node_nxt  = top_r;
            depth_nxt = '0;
          end else begin
            need_reload = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.emit     = emit;
  assign stat.reload   = need_reload;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
    if (cmd.exec && push_we) begin
      stk_mem[wr_addr] <= '{node: top_r, cursor: cur_r + 1'b1};
    end
    rd_q <= stk_mem[rd_addr];
    if (cmd.exec && emit) begin
      out_event_r <= ev_nxt;
      out_node_r  <= node_nxt;
      out_depth_r <= depth_nxt;
    end
    if (cmd.exec) begin
      top_r <= top_nxt;
      cur_r <= cur_nxt;
    end else if (cmd.reload) begin
      top_r <= rd_q.node;
      cur_r <= rd_q.cursor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        adj_r[i] <= '0;
      end
      onpath_r    <= '0;
      nc_r        <= COUNT_RESET;
      sd_r        <= '0;
      walk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        nc_r <= cfg_data;
      end
      if (cmd.exec) begin
        onpath_r <= onpath_nxt;
        sd_r     <= sd_nxt;
        walk_r   <= walk_nxt;
        if (item_r.kind == KIND_LOAD) begin
          adj_r[item_r.row_index] <= item_r.row_bits;
        end
      end
      if (cmd.exec && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_event = out_event_r;
  assign out_node  = out_node_r;
  assign out_depth = out_depth_r;

endmodule

// File: dv/dfs_path_enumerator_core_test.sv
// Self-checking testbench for dfs_path_enumerator_core: directed and random item streams
// with random idling on both channels, checked against a cycle-free walk predictor.
// Depends on dfs_pkg, the channel interfaces and the core RTL.
`timescale 1ns / 1ps

module dfs_path_enumerator_core_test
  import dfs_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 400;
  localparam int PHASE_ITEMS  = 56;
  localparam int NUM_PHASES   = 8;

  typedef enum logic [1:0] {MARK_OUTSIDE, MARK_ON_PATH, MARK_FINISHED} mark_e;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [NODE_W-1:0]  node;
    logic [DEPTH_W-1:0] depth;
  } walk_event_t;

  typedef struct {
    item_t       it;
    bit          fixed;
    walk_event_t ev;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n;

  dfs_item_if   in_if();
  dfs_result_if out_if();
  dfs_cfg_if    cfg_if();

  dfs_path_enumerator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  logic [ROW_W-1:0]   adj_rows     [MAX_NODES];
  mark_e              marks        [MAX_NODES];
  logic [NODE_W-1:0]  path_stack   [MAX_NODES];
  logic [DEPTH_W-1:0] cursor_stack [MAX_NODES];
  int                 walk_depth;
  bit                 walk_on;
  logic [DEPTH_W-1:0] node_count_q;

  walk_event_t pending_events[$];
  vector_t     directed_vectors[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          long_stall_req = 1'b0;
  bit          long_stall_done = 1'b0;
  int          phase_counts[NUM_PHASES] = '{5, 32, 1, 0, 63, 8, 2, 4};

  function automatic int active_nodes();
    return (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
  endfunction

  function automatic walk_event_t make_event(logic [EVENT_W-1:0] ev, logic [NODE_W-1:0] nd,
                                             logic [DEPTH_W-1:0] dp);
    walk_event_t e;
    e.event_res = ev;
    e.node      = nd;
    e.depth     = dp;
    return e;
  endfunction

  function automatic item_t make_item(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] idx,
                                      logic [ROW_W-1:0] bits, logic [NODE_W-1:0] src);
    item_t it;
    it.kind        = kind;
    it.row_index   = idx;
    it.row_bits    = bits;
    it.source_node = src;
    return it;
  endfunction

  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom & $urandom;
      2: return $urandom & $urandom & $urandom;
      3: return ROW_W'(1) << $urandom_range(0, ROW_W - 1);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [NODE_W-1:0] pick_node(int n, int in_range_pct);
    if (n > 0 && $urandom_range(0, 99) < in_range_pct) return NODE_W'($urandom_range(0, n - 1));
    return NODE_W'($urandom_range(0, MAX_NODES - 1));
  endfunction

  task automatic reset_model();
    for (int i = 0; i < MAX_NODES; i++) begin
      adj_rows[i]     = '0;
      marks[i]        = MARK_OUTSIDE;
      path_stack[i]   = '0;
      cursor_stack[i] = '0;
    end
    walk_depth   = 0;
    walk_on      = 1'b0;
    node_count_q = COUNT_RESET;
  endtask

  task automatic advance_walk(input item_t it, output bit emits, output walk_event_t ev,
                              output bit counted);
    int n;
    int lvl;
    int y;
    logic [NODE_W-1:0] top;
    emits   = 1'b0;
    ev      = '0;
    counted = 1'b1;
    n       = active_nodes();
    case (it.kind)
      KIND_LOAD: adj_rows[it.row_index] = it.row_bits;
      KIND_START: begin
        if (int'(it.source_node) >= n) begin
          emits = 1'b1;
          ev    = make_event(EV_REJECT, it.source_node, '0);
        end else begin
          for (int i = 0; i < MAX_NODES; i++) marks[i] = MARK_OUTSIDE;
          marks[it.source_node] = MARK_ON_PATH;
          path_stack[0]   = it.source_node;
          cursor_stack[0] = '0;
          walk_depth      = 1;
          walk_on         = 1'b1;
        end
      end
      KIND_STEP: begin
        if (!walk_on || walk_depth == 0 || walk_depth > MAX_NODES) begin
          walk_on = 1'b0;
          counted = 1'b0;
        end else begin
          lvl = walk_depth - 1;
          top = path_stack[lvl];
          if (int'(cursor_stack[lvl]) < n) begin
            y = int'(cursor_stack[lvl]);
            cursor_stack[lvl] = DEPTH_W'(y + 1);
            if (adj_rows[top][y]) begin
              if (marks[y] == MARK_ON_PATH) begin
                emits = 1'b1;
                ev    = make_event(EV_CIRCUIT, NODE_W'(y), DEPTH_W'(walk_depth));
              end else if (walk_depth < MAX_NODES) begin
                path_stack[walk_depth]   = NODE_W'(y);
                cursor_stack[walk_depth] = '0;
                walk_depth++;
                marks[y] = MARK_ON_PATH;
                emits    = 1'b1;
                ev       = make_event(EV_EXTEND, NODE_W'(y), DEPTH_W'(walk_depth));
              end
            end
          end else begin
            marks[top] = MARK_FINISHED;
            walk_depth--;
            if (walk_depth == 0) begin
              walk_on = 1'b0;
              emits   = 1'b1;
              ev      = make_event(EV_DONE, top, '0);
            end
          end
        end
      end
      default: counted = 1'b0;
    endcase
  endtask

  task automatic send_item(input item_t it, input bit fixed, input walk_event_t fixed_ev);
    bit          emits;
    bit          counted;
    walk_event_t ev;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.kind        <= it.kind;
    in_if.row_index   <= it.row_index;
    in_if.row_bits    <= it.row_bits;
    in_if.source_node <= it.source_node;
    in_if.valid       <= 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    advance_walk(it, emits, ev, counted);
    if (fixed) pending_events.push_back(fixed_ev);
    else if (emits) pending_events.push_back(ev);
    if (counted) items_sent++;
    @(negedge clk);
  endtask

  task automatic write_node_count(input logic [DEPTH_W-1:0] value);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    node_count_q = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_walk_sequence();
    int n;
    int budget;
    n = active_nodes();
    repeat ($urandom_range(1, 8))
      send_item(make_item(KIND_LOAD, pick_node(n, 75), random_row(), NODE_W'($urandom)),
                1'b0, '0);
    send_item(make_item(KIND_START, NODE_W'($urandom), $urandom, pick_node(n, 90)), 1'b0, '0);
    budget = $urandom_range(8, 150);
    while (walk_on && budget > 0) begin
      if ($urandom_range(0, 9) == 0)
        send_item(make_item(KIND_W'($urandom_range(0, 3)), NODE_W'($urandom), random_row(),
                            NODE_W'($urandom)), 1'b0, '0);
      else
        send_item(make_item(KIND_STEP, NODE_W'($urandom), $urandom, NODE_W'($urandom)),
                  1'b0, '0);
      budget--;
    end
  endtask

  task automatic add_vector(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] idx,
                            logic [ROW_W-1:0] bits, logic [NODE_W-1:0] src, bit fixed,
                            walk_event_t ev);
    vector_t v;
    v.it    = make_item(kind, idx, bits, src);
    v.fixed = fixed;
    v.ev    = ev;
    directed_vectors.push_back(v);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    walk_event_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: event %0d node %0d depth %0d",
                   out_if.event_res, out_if.node, out_if.depth);
      end else begin
        want = pending_events.pop_front();
        if (out_if.event_res !== want.event_res || out_if.node !== want.node ||
            out_if.depth !== want.depth) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("Result mismatch: expected event %0d node %0d depth %0d, ",
                   want.event_res, want.node, want.depth);
            $display("got event %0d node %0d depth %0d",
                     out_if.event_res, out_if.node, out_if.depth);
          end
        end
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req && !long_stall_done) begin
        long_stall_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = '0;
    in_if.row_index   = '0;
    in_if.row_bits    = '0;
    in_if.source_node = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    reset_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 32;
    recv_idle_pct   = 65;
    write_node_count(DEPTH_W'(3));
    add_vector(2'd3, 5'd31, '1, 5'd31, 1'b0, '0);
    add_vector(KIND_STEP, '0, '0, '0, 1'b0, '0);
    add_vector(KIND_LOAD, 5'd31, '0, '0, 1'b0, '0);
    add_vector(KIND_START, '0, '0, 5'd31, 1'b1, make_event(EV_REJECT, 5'd31, '0));
    add_vector(KIND_START, '0, '0, 5'd3, 1'b1, make_event(EV_REJECT, 5'd3, '0));
    add_vector(KIND_LOAD, 5'd0, 32'h0000_0006, '0, 1'b0, '0);
    add_vector(KIND_LOAD, 5'd2, '1, '0, 1'b0, '0);
    add_vector(KIND_START, '0, '0, 5'd0, 1'b0, '0);
    add_vector(KIND_LOAD, 5'd1, 32'h0000_0001, '0, 1'b0, '0);
    repeat (15) add_vector(KIND_STEP, '0, '0, '0, 1'b0, '0);
    add_vector(KIND_STEP, '0, '0, '0, 1'b1, make_event(EV_DONE, 5'd0, '0));
    foreach (directed_vectors[i])
      send_item(directed_vectors[i].it, directed_vectors[i].fixed, directed_vectors[i].ev);
    in_if.valid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int target;
      if (ph < 3) begin
        sender_idle_pct = 32;
        recv_idle_pct   = 65;
      end else if (ph < 6) begin
        sender_idle_pct = 65;
        recv_idle_pct   = 32;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      write_node_count(DEPTH_W'(phase_counts[ph]));
      if (ph == 1) long_stall_req = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_walk_sequence();
      in_if.valid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0 && pending_events.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/dfs_pkg.sv
sv/dfs_if.sv
sv/dfs_ctrl.sv
sv/dfs_datapath.sv
sv/dfs_path_enumerator_core.sv
dv/dfs_path_enumerator_core_test.sv
